>>> sv/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types, widths and helpers for the count-min sketch unit.
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam int KEY_W          = 32;
    localparam int INC_W          = 16;
    localparam int CNT_W          = 32;
    localparam int COEFF_W        = 64;
    localparam int HALF_W         = 32;
    localparam int NUM_COEFF_REGS = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int ROW_W          = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic OP_UPDATE   = 1'b0;
    localparam logic OP_ESTIMATE = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_FIX,
        S_READ,
        S_RMW,
        S_DONE
    } cms_state_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] x,
                                                 input logic [CNT_W-1:0] y);
        logic [CNT_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

>>> sv/cms_if.sv
// ----------------------------------------------------------------------------
// cms_if
// Request and response channels of the count-min sketch unit.
// ----------------------------------------------------------------------------
interface cms_req_if
    import cms_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             op;
    logic [KEY_W-1:0] item_key;
    logic [INC_W-1:0] increment;

    modport source (output valid, output op, output item_key, output increment,
                    input ready);
    modport sink   (input valid, input op, input item_key, input increment,
                    output ready);
endinterface

interface cms_rsp_if
    import cms_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] estimate;
    logic [CNT_W-1:0] total;

    modport source (output valid, output estimate, output total, input ready);
    modport sink   (input valid, input estimate, input total, output ready);
endinterface

>>> sv/count_min_sketch_unit.sv
// operation: one item at a time; a new request beat is taken only once the last item is back in
//   idle; each row takes a hash multiply, a reciprocal multiply, a correcting subtract
//   and a read-modify-write of the single-port counter memory; a stalled response
//   holds the unit in its last state
// reset: a clearing pass writes zero to all ROWS*WIDTH counters before the first
//   request beat; coefficient writes are taken meanwhile
// ----------------------------------------------------------------------------
// count_min_sketch_unit
// Count-min sketch: ROWS rows of WIDTH saturating counters in one memory.
// ----------------------------------------------------------------------------
module count_min_sketch_unit
    import cms_pkg::*;
#(
    parameter int ROWS  = 5,
    parameter int WIDTH = 272
) (
    input  logic                 clk,
    input  logic                 rst_n,
    cms_req_if.sink              req,
    cms_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEFF_W-1:0]   cfg_wdata
);

    localparam int DEPTH = ROWS * WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(WIDTH);
    localparam logic [HALF_W-1:0] RECIP = HALF_W'((64'd1 << HALF_W) / WIDTH);

    cms_state_t         state_reg, state_next;
    logic [COEFF_W-1:0] coeff_reg [NUM_COEFF_REGS];

    logic               op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [INC_W-1:0]   inc_reg, inc_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [KEY_W-1:0]   hash_reg, hash_next;
    logic [HALF_W-1:0]  quot_reg, quot_next;
    logic [RW-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]   min_reg, min_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic               out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]   est_out_reg, est_out_next;
    logic [CNT_W-1:0]   total_out_reg, total_out_next;

    logic [CNT_W-1:0]   mem [DEPTH];
    logic [CNT_W-1:0]   rd_data_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [CNT_W-1:0]   mem_wdata;

    logic [HALF_W-1:0]  coeff_a;
    logic [HALF_W-1:0]  coeff_b;
    logic [KEY_W-1:0]   hash_calc;
    logic [2*HALF_W-1:0] recip_prod;
    logic [KEY_W-1:0]   part_rem;

    // hash: wraps modulo 2^32
    assign coeff_a   = coeff_reg[row_reg][COEFF_W-1:HALF_W];
    assign coeff_b   = coeff_reg[row_reg][HALF_W-1:0];
    assign hash_calc = coeff_a * key_reg + coeff_b;

    // bucket: reciprocal estimate of the quotient is low by at most one,
    // so one compare and subtract finishes the remainder
    assign recip_prod = (2*HALF_W)'(hash_reg) * (2*HALF_W)'(RECIP);
    assign part_rem   = hash_reg - quot_reg * KEY_W'(WIDTH);

    assign mem_addr = (state_reg == S_CLEAR) ? clr_addr_reg : base_reg + AW'(rem_reg);

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.estimate = est_out_reg;
    assign rsp.total    = total_out_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        inc_next       = inc_reg;
        total_next     = total_reg;
        row_next       = row_reg;
        base_next      = base_reg;
        hash_next      = hash_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        min_next       = min_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        est_out_next   = est_out_reg;
        total_out_next = total_out_reg;
        mem_we         = 1'b0;
        mem_wdata      = sat_add(rd_data_reg, CNT_W'(inc_reg));

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next   = req.op;
                    key_next  = req.item_key;
                    inc_next  = req.increment;
                    row_next  = '0;
                    base_next = '0;
                    min_next  = CNT_MAX;
                    if (req.op == OP_UPDATE)
                    begin
                        total_next = sat_add(total_reg, CNT_W'(req.increment));
                    end
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                hash_next  = hash_calc;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                quot_next  = recip_prod[2*HALF_W-1:HALF_W];
                state_next = S_FIX;
            end
            S_FIX:
            begin
                if (part_rem >= KEY_W'(WIDTH))
                begin
                    rem_next = RW'(part_rem - KEY_W'(WIDTH));
                end
                else
                begin
                    rem_next = RW'(part_rem);
                end
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_RMW;
            end
            S_RMW:
            begin
                // accesses are strictly one after another, so no forwarding is needed
                if (op_reg == OP_UPDATE)
                begin
                    mem_we = 1'b1;
                end
                else if (rd_data_reg < min_reg)
                begin
                    min_next = rd_data_reg;
                end
                if (row_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    base_next  = base_reg + AW'(WIDTH);
                    state_next = S_HASH;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    est_out_next   = (op_reg == OP_ESTIMATE) ? min_reg : '0;
                    total_out_next = total_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            total_reg     <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_COEFF_REGS; i++)
            begin
                coeff_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_COEFF_REGS)))
            begin
                coeff_reg[cfg_index] <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        inc_reg       <= inc_next;
        row_reg       <= row_next;
        base_reg      <= base_next;
        hash_reg      <= hash_next;
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        min_reg       <= min_next;
        est_out_reg   <= est_out_next;
        total_out_reg <= total_out_next;
    end

    // counter memory, one read-or-write port, registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while an item is in flight");

    a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> ({1'b0, rem_reg} < (RW+1)'(WIDTH)))
        else $error("bucket index beyond row width");

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg >= $past(total_reg))
        else $error("running total went down");

    a_write_guard: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR
                    || (state_reg == S_RMW && op_reg == OP_UPDATE)))
        else $error("counter write outside clear or update");

endmodule
